@@ src/vts_pkg.sv @@
// ----------------------------------------------------------------------------
// VHDL token scanner package
// Shared widths, token and error codes, character classes and the step and
// token records that travel between the scanner's front end and back end.
// ----------------------------------------------------------------------------
package vts_pkg;

  localparam int OFFSET_W = 32;
  localparam int LINE_W   = 24;
  localparam int COL_W    = 16;

  typedef logic [OFFSET_W-1:0] off_t;
  typedef logic [LINE_W-1:0]   line_t;
  typedef logic [COL_W-1:0]    col_t;

  // Token kinds.
  localparam logic [3:0] K_IDENT   = 4'd0;
  localparam logic [3:0] K_EXTID   = 4'd1;
  localparam logic [3:0] K_INT     = 4'd2;
  localparam logic [3:0] K_REAL    = 4'd3;
  localparam logic [3:0] K_STRING  = 4'd4;
  localparam logic [3:0] K_CHAR    = 4'd5;
  localparam logic [3:0] K_SYMBOL  = 4'd6;
  localparam logic [3:0] K_INVALID = 4'd7;
  localparam logic [3:0] K_EOF     = 4'd8;

  // Error codes of invalid tokens.
  localparam logic [3:0] E_NONE        = 4'd0;
  localparam logic [3:0] E_IDENT       = 4'd1;
  localparam logic [3:0] E_EXTID_OPEN  = 4'd2;
  localparam logic [3:0] E_DEC_SEP     = 4'd3;
  localparam logic [3:0] E_BASED_OPEN  = 4'd4;
  localparam logic [3:0] E_BASED_SEP   = 4'd5;
  localparam logic [3:0] E_BEXP_EMPTY  = 4'd6;
  localparam logic [3:0] E_BEXP_SEP    = 4'd7;
  localparam logic [3:0] E_FRAC_SEP    = 4'd8;
  localparam logic [3:0] E_EXP_EMPTY   = 4'd9;
  localparam logic [3:0] E_EXP_SEP     = 4'd10;
  localparam logic [3:0] E_STRING_OPEN = 4'd11;
  localparam logic [3:0] E_BAD_CHAR    = 4'd12;

  // Input modes.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // Characters.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_LE     = 8'h65;

  typedef struct packed {
    off_t  off;
    line_t line;
    col_t  col;
  } pos_t;

  // One unit of work for the back end: either one byte with its lookahead,
  // or the end-of-source finish.
  typedef struct packed {
    logic       fin;
    logic [7:0] c;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
    logic       last;
  } step_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] err;
    pos_t       first;
    pos_t       stop;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF};
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == CH_UE) || (c == CH_LE);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c inside {CH_AMP, CH_QUOTE, CH_LPAR, CH_RPAR, CH_STAR, CH_PLUS, CH_COMMA,
                     CH_MINUS, CH_DOT, CH_SLASH, CH_COLON, CH_SEMI, CH_LT, CH_EQ,
                     CH_GT, CH_BAR, CH_LBRK, CH_RBRK, CH_QMARK};
  endfunction

  function automatic logic is_compound(input logic [7:0] a, input logic [7:0] b);
    return ((a == CH_COLON) && (b == CH_EQ)) || ((a == CH_LT) && (b == CH_EQ)) ||
           ((a == CH_GT) && (b == CH_EQ)) || ((a == CH_SLASH) && (b == CH_EQ)) ||
           ((a == CH_EQ) && (b == CH_GT)) || ((a == CH_STAR) && (b == CH_STAR)) ||
           ((a == CH_LT) && (b == CH_GT));
  endfunction

  // Cursor after one byte; line and column saturate, the offset wraps.
  function automatic pos_t pos_adv(input pos_t p, input logic [7:0] c);
    pos_t r;
    r = p;
    r.off = p.off + off_t'(1);
    if (c == CH_LF) begin
      if (p.line != {LINE_W{1'b1}}) r.line = p.line + line_t'(1);
      r.col = col_t'(1);
    end else if (p.col != {COL_W{1'b1}}) begin
      r.col = p.col + col_t'(1);
    end
    return r;
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [3:0] err,
                                  input pos_t first, input pos_t stop);
    tok_t t;
    t.kind  = kind;
    t.err   = err;
    t.first = first;
    t.stop  = stop;
    return t;
  endfunction

endpackage

@@ src/vts_front.sv @@
// ----------------------------------------------------------------------------
// Scanner front end
// Holds the three-byte lookahead window and turns input beats into steps.
// An end beat is expanded into one step per held byte and a finish step.
// ----------------------------------------------------------------------------
module vts_front import vts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] source_byte,
  output logic       step_valid,
  input  logic       step_ready,
  output step_t      step
);

  logic [7:0] win_r [3];
  logic [7:0] win_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic       flush_r, flush_nxt;
  logic       in_fire;

  assign in_ready = !flush_r && step_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    flush_nxt  = flush_r;
    step_valid = 1'b0;
    step       = '0;
    if (flush_r) begin
      step_valid = 1'b1;
      if (cnt_r != 2'd0) begin
        step.c  = win_r[0];
        step.p1 = (cnt_r > 2'd1) ? win_r[1] : CH_NUL;
        step.p2 = (cnt_r > 2'd2) ? win_r[2] : CH_NUL;
      end else begin
        step.fin  = 1'b1;
        step.last = 1'b1;
      end
      if (step_ready) begin
        if (cnt_r != 2'd0) begin
          win_nxt[0] = win_r[1];
          win_nxt[1] = win_r[2];
          cnt_nxt    = cnt_r - 2'd1;
        end else begin
          flush_nxt = 1'b0;
        end
      end
    end else if (in_fire) begin
      if (mode == MODE_END) begin
        flush_nxt = 1'b1;
      end else if (cnt_r == 2'd3) begin
        step_valid = 1'b1;
        step.c     = win_r[0];
        step.p1    = win_r[1];
        step.p2    = win_r[2];
        step.p3    = source_byte;
        step.last  = 1'b1;
        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = source_byte;
      end else begin
        win_nxt[cnt_r] = source_byte;
        cnt_nxt        = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      flush_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

@@ src/vts_queue.sv @@
// ----------------------------------------------------------------------------
// Step queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module vts_queue import vts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  step_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output step_t rd_data
);

  step_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_fire, rd_fire;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_fire) wp_r <= !wp_r;
      if (rd_fire) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_fire} - {1'b0, rd_fire};
    end
  end

endmodule

@@ src/vts_back.sv @@
// ----------------------------------------------------------------------------
// Scanner back end
// Token state machine. Each step yields at most two tokens: one closing the
// token in progress and one finished by the same byte, or the end-of-file token.
// ----------------------------------------------------------------------------
module vts_back import vts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_valid,
  output logic  step_ready,
  input  step_t step,
  output logic  out_valid,
  input  logic  out_ready,
  output tok_t  out_tok,
  output logic  out_last
);

  typedef enum logic [18:0] {
    ST_IDLE       = 19'h00001,
    ST_COMMENT    = 19'h00002,
    ST_IDENT      = 19'h00004,
    ST_EXTID      = 19'h00008,
    ST_EXTID_ESC  = 19'h00010,
    ST_DEC        = 19'h00020,
    ST_BASED      = 19'h00040,
    ST_BASED_AFT  = 19'h00080,
    ST_BEXP_SIGN  = 19'h00100,
    ST_BEXP_FIRST = 19'h00200,
    ST_BEXP_DIG   = 19'h00400,
    ST_FRAC       = 19'h00800,
    ST_EXP_SIGN   = 19'h01000,
    ST_EXP_FIRST  = 19'h02000,
    ST_EXP_DIG    = 19'h04000,
    ST_STRING     = 19'h08000,
    ST_STR_ESC    = 19'h10000,
    ST_CHAR       = 19'h20000,
    ST_SYM2       = 19'h40000
  } scan_state_t;

  scan_state_t st_r, st_nxt;
  logic        bad_r, bad_nxt;
  logic        real_r, real_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [7:0]  prev_r, prev_nxt;
  pos_t        cur_r, cur_nxt;
  pos_t        tst_r, tst_nxt;

  logic        out_valid_r, out_valid_nxt;
  tok_t        out_tok_r, out_tok_nxt;
  logic        out_last_r, out_last_nxt;
  logic        pend_r, pend_nxt;
  tok_t        pend_tok_r, pend_tok_nxt;
  logic        pend_last_r, pend_last_nxt;

  logic        t1_v, t2_v, done, slot_free, take;
  tok_t        t1, t2;
  logic [7:0]  c, p1, p2, p3;

  assign c  = step.c;
  assign p1 = step.p1;
  assign p2 = step.p2;
  assign p3 = step.p3;

  assign slot_free  = !out_valid_r || out_ready;
  assign take       = !pend_r && step_valid && slot_free;
  assign step_ready = !pend_r && slot_free;

  // Next scanner state and the tokens of one step.
  always_comb begin
    st_nxt   = st_r;
    bad_nxt  = bad_r;
    real_nxt = real_r;
    rem_nxt  = rem_r;
    prev_nxt = prev_r;
    cur_nxt  = cur_r;
    tst_nxt  = tst_r;
    t1_v     = 1'b0;
    t2_v     = 1'b0;
    t1       = '0;
    t2       = '0;
    done     = 1'b0;
    if (step.fin) begin
      t1_v = 1'b1;
      case (st_nxt)
        ST_IDENT:
          t1 = (bad_r || prev_r == CH_UNDER) ? mk_tok(K_INVALID, E_IDENT, tst_r, cur_r)
                                            : mk_tok(K_IDENT, E_NONE, tst_r, cur_r);
        ST_EXTID, ST_EXTID_ESC: t1 = mk_tok(K_INVALID, E_EXTID_OPEN, tst_r, cur_r);
        ST_DEC:
          t1 = bad_r ? mk_tok(K_INVALID, E_DEC_SEP, tst_r, cur_r)
                     : mk_tok(K_INT, E_NONE, tst_r, cur_r);
        ST_BASED: t1 = mk_tok(K_INVALID, E_BASED_OPEN, tst_r, cur_r);
        ST_BASED_AFT:
          t1 = mk_tok(real_r ? K_REAL : K_INT, E_NONE, tst_r, cur_r);
        ST_BEXP_SIGN, ST_BEXP_FIRST: t1 = mk_tok(K_INVALID, E_BEXP_EMPTY, tst_r, cur_r);
        ST_BEXP_DIG:
          t1 = bad_r ? mk_tok(K_INVALID, E_BEXP_SEP, tst_r, cur_r)
                     : mk_tok(K_REAL, E_NONE, tst_r, cur_r);
        ST_FRAC:
          t1 = bad_r ? mk_tok(K_INVALID, E_FRAC_SEP, tst_r, cur_r)
                     : mk_tok(K_REAL, E_NONE, tst_r, cur_r);
        ST_EXP_SIGN, ST_EXP_FIRST: t1 = mk_tok(K_INVALID, E_EXP_EMPTY, tst_r, cur_r);
        ST_EXP_DIG:
          t1 = bad_r ? mk_tok(K_INVALID, E_EXP_SEP, tst_r, cur_r)
                     : mk_tok(K_REAL, E_NONE, tst_r, cur_r);
        ST_STRING, ST_STR_ESC: t1 = mk_tok(K_INVALID, E_STRING_OPEN, tst_r, cur_r);
        ST_CHAR: t1 = mk_tok(K_CHAR, E_NONE, tst_r, cur_r);
        ST_SYM2: t1 = mk_tok(K_SYMBOL, E_NONE, tst_r, cur_r);
        default: t1_v = 1'b0;
      endcase
      t2_v          = 1'b1;
      t2            = mk_tok(K_EOF, E_NONE, cur_r, cur_r);
      // The block starts a fresh source after the end-of-file token.
      st_nxt        = ST_IDLE;
      bad_nxt       = 1'b0;
      real_nxt      = 1'b0;
      rem_nxt       = 2'd0;
      prev_nxt      = CH_NUL;
      cur_nxt.off   = '0;
      cur_nxt.line  = line_t'(1);
      cur_nxt.col   = col_t'(1);
    end else begin
      // Transitions that consume nothing or only an exponent sign.
      case (st_nxt)
        ST_COMMENT: if (c == CH_LF) st_nxt = ST_IDLE;
        ST_BEXP_SIGN, ST_EXP_SIGN: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            cur_nxt  = pos_adv(cur_nxt, c);
            prev_nxt = c;
            done     = 1'b1;
          end
          st_nxt = (st_r == ST_BEXP_SIGN) ? ST_BEXP_FIRST : ST_EXP_FIRST;
        end
        default: ;
      endcase
      // A byte that cannot extend the current token closes it.
      if (!done) begin
        case (st_nxt)
          ST_IDENT:
            if (!(is_alnum(c) || c == CH_UNDER)) begin
              t1_v = 1'b1;
              t1 = (bad_nxt || prev_nxt == CH_UNDER)
                   ? mk_tok(K_INVALID, E_IDENT, tst_nxt, cur_nxt)
                   : mk_tok(K_IDENT, E_NONE, tst_nxt, cur_nxt);
            end
          ST_DEC:
            if (!(is_digit(c) || c == CH_UNDER)) begin
              if (bad_nxt) begin
                t1_v = 1'b1;
                t1   = mk_tok(K_INVALID, E_DEC_SEP, tst_nxt, cur_nxt);
              end else if (!(c == CH_HASH || (c == CH_DOT && is_digit(p1)) || is_exp(c))) begin
                t1_v = 1'b1;
                t1   = mk_tok(K_INT, E_NONE, tst_nxt, cur_nxt);
              end
            end
          ST_BASED_AFT:
            if (!is_exp(c)) begin
              t1_v = 1'b1;
              t1   = mk_tok(real_nxt ? K_REAL : K_INT, E_NONE, tst_nxt, cur_nxt);
            end
          ST_BEXP_FIRST, ST_EXP_FIRST:
            if (!is_digit(c)) begin
              t1_v = 1'b1;
              t1   = mk_tok(K_INVALID, (st_nxt == ST_BEXP_FIRST) ? E_BEXP_EMPTY : E_EXP_EMPTY,
                            tst_nxt, cur_nxt);
            end
          ST_BEXP_DIG, ST_EXP_DIG:
            if (!(is_digit(c) || c == CH_UNDER)) begin
              t1_v = 1'b1;
              if (bad_nxt)
                t1 = mk_tok(K_INVALID, (st_nxt == ST_BEXP_DIG) ? E_BEXP_SEP : E_EXP_SEP,
                            tst_nxt, cur_nxt);
              else
                t1 = mk_tok(K_REAL, E_NONE, tst_nxt, cur_nxt);
            end
          ST_FRAC:
            if (!(is_digit(c) || c == CH_UNDER)) begin
              if (bad_nxt) begin
                t1_v = 1'b1;
                t1   = mk_tok(K_INVALID, E_FRAC_SEP, tst_nxt, cur_nxt);
              end else if (!is_exp(c)) begin
                t1_v = 1'b1;
                t1   = mk_tok(K_REAL, E_NONE, tst_nxt, cur_nxt);
              end
            end
          default: ;
        endcase
        if (t1_v) begin
          st_nxt   = ST_IDLE;
          bad_nxt  = 1'b0;
          real_nxt = 1'b0;
          rem_nxt  = 2'd0;
        end
      end
      // Consume the byte.
      if (!done) begin
        case (st_nxt)
          ST_IDLE: begin
            if (is_space(c)) begin
              // Whitespace only moves the cursor.
            end else if (c == CH_MINUS && p1 == CH_MINUS) begin
              st_nxt = ST_COMMENT;
            end else begin
              tst_nxt  = cur_nxt;
              bad_nxt  = 1'b0;
              real_nxt = 1'b0;
              rem_nxt  = 2'd0;
              if (is_alpha(c)) st_nxt = ST_IDENT;
              else if (c == CH_BSLASH) st_nxt = ST_EXTID;
              else if (is_digit(c)) st_nxt = ST_DEC;
              else if (c == CH_DQUOTE) st_nxt = ST_STRING;
              else if (c == CH_QUOTE && p1 == CH_QUOTE && p2 == CH_QUOTE && p3 == CH_QUOTE) begin
                rem_nxt = 2'd3;
                st_nxt  = ST_CHAR;
              end else if (c == CH_QUOTE && p1 != CH_NUL && p2 == CH_QUOTE && p1 != CH_LF) begin
                rem_nxt = 2'd2;
                st_nxt  = ST_CHAR;
              end else if (is_punct(c) && is_compound(c, p1)) begin
                st_nxt = ST_SYM2;
              end else begin
                t2_v = 1'b1;
                t2   = mk_tok(is_punct(c) ? K_SYMBOL : K_INVALID,
                              is_punct(c) ? E_NONE : E_BAD_CHAR,
                              cur_nxt, pos_adv(cur_nxt, c));
              end
            end
          end
          ST_IDENT: if (c == CH_UNDER && prev_nxt == CH_UNDER) bad_nxt = 1'b1;
          ST_EXTID:
            if (c == CH_BSLASH) begin
              if (p1 == CH_BSLASH) st_nxt = ST_EXTID_ESC;
              else begin
                t2_v = 1'b1;
                t2   = mk_tok(K_EXTID, E_NONE, tst_nxt, pos_adv(cur_nxt, c));
              end
            end
          ST_EXTID_ESC: st_nxt = ST_EXTID;
          ST_DEC:
            if (is_digit(c) || c == CH_UNDER) begin
              if (c == CH_UNDER && !(is_digit(prev_nxt) && is_digit(p1))) bad_nxt = 1'b1;
            end else if (c == CH_HASH) begin
              bad_nxt  = 1'b0;
              real_nxt = 1'b0;
              st_nxt   = ST_BASED;
            end else if (c == CH_DOT) begin
              st_nxt = ST_FRAC;
            end else begin
              st_nxt = ST_EXP_SIGN;
            end
          ST_BASED:
            if (c != CH_HASH) begin
              if (c == CH_DOT) real_nxt = 1'b1;
              if (c == CH_UNDER && !(is_alnum(prev_nxt) && is_alnum(p1))) bad_nxt = 1'b1;
            end else if (bad_nxt) begin
              t2_v = 1'b1;
              t2   = mk_tok(K_INVALID, E_BASED_SEP, tst_nxt, pos_adv(cur_nxt, c));
            end else begin
              st_nxt = ST_BASED_AFT;
            end
          ST_BASED_AFT: begin
            real_nxt = 1'b1;
            st_nxt   = ST_BEXP_SIGN;
          end
          ST_BEXP_FIRST: st_nxt = ST_BEXP_DIG;
          ST_EXP_FIRST:  st_nxt = ST_EXP_DIG;
          ST_BEXP_DIG, ST_EXP_DIG, ST_FRAC:
            if (is_digit(c) || c == CH_UNDER) begin
              if (c == CH_UNDER && !(is_digit(prev_nxt) && is_digit(p1))) bad_nxt = 1'b1;
            end else begin
              st_nxt = ST_EXP_SIGN;
            end
          ST_STRING:
            if (c == CH_DQUOTE) begin
              if (p1 == CH_DQUOTE) st_nxt = ST_STR_ESC;
              else begin
                t2_v = 1'b1;
                t2   = mk_tok(K_STRING, E_NONE, tst_nxt, pos_adv(cur_nxt, c));
              end
            end
          ST_STR_ESC: st_nxt = ST_STRING;
          ST_CHAR:
            if (rem_nxt <= 2'd1) begin
              t2_v = 1'b1;
              t2   = mk_tok(K_CHAR, E_NONE, tst_nxt, pos_adv(cur_nxt, c));
            end else begin
              rem_nxt = rem_nxt - 2'd1;
            end
          ST_SYM2: begin
            t2_v = 1'b1;
            t2   = mk_tok(K_SYMBOL, E_NONE, tst_nxt, pos_adv(cur_nxt, c));
          end
          default: ;
        endcase
        cur_nxt  = pos_adv(cur_nxt, c);
        prev_nxt = c;
        if (t2_v) begin
          st_nxt   = ST_IDLE;
          bad_nxt  = 1'b0;
          real_nxt = 1'b0;
          rem_nxt  = 2'd0;
        end
      end
    end
  end

  // Output register plus one holding slot for the second token of a step.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_tok_nxt   = out_tok_r;
    out_last_nxt  = out_last_r;
    pend_nxt      = pend_r;
    pend_tok_nxt  = pend_tok_r;
    pend_last_nxt = pend_last_r;
    if (pend_r && slot_free) begin
      out_valid_nxt = 1'b1;
      out_tok_nxt   = pend_tok_r;
      out_last_nxt  = pend_last_r;
      pend_nxt      = 1'b0;
    end else if (take && (t1_v || t2_v)) begin
      out_valid_nxt = 1'b1;
      out_tok_nxt   = t1_v ? t1 : t2;
      out_last_nxt  = step.last && !(t1_v && t2_v);
      if (t1_v && t2_v) begin
        pend_nxt      = 1'b1;
        pend_tok_nxt  = t2;
        pend_last_nxt = step.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tok_r   <= out_tok_nxt;
    out_last_r  <= out_last_nxt;
    pend_tok_r  <= pend_tok_nxt;
    pend_last_r <= pend_last_nxt;
    if (take) tst_r <= tst_nxt;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      bad_r       <= 1'b0;
      real_r      <= 1'b0;
      rem_r       <= 2'd0;
      prev_r      <= CH_NUL;
      cur_r.off   <= '0;
      cur_r.line  <= line_t'(1);
      cur_r.col   <= col_t'(1);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (take) begin
        st_r   <= st_nxt;
        bad_r  <= bad_nxt;
        real_r <= real_nxt;
        rem_r  <= rem_nxt;
        prev_r <= prev_nxt;
        cur_r  <= cur_nxt;
      end
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;
  assign out_last  = out_last_r;

endmodule

@@ src/vhdl_token_scanner.sv @@
// ----------------------------------------------------------------------------
// VHDL token scanner
// Streams VHDL source bytes in and token records out.
//
//   channel  direction  beat contents
//   in_      input      mode, source_byte
//   out_     output     token_kind, error_code, position fields, last_of_run
//
// A source byte beat can be taken every cycle while the step queue has room
// and no end beat drains. A byte's step passes through the step queue, and
// the back end registers its tokens into the output register as it scans the
// byte; a byte that closes one token and forms another parks the second in
// the back end's holding slot. An end beat occupies the front end while the
// window drains and the end-of-file finish step is sent. Reset is synchronous;
// the block can take a beat as soon as reset is released. Stalls on the output
// back up through the two-entry step queue to in_ready.
// ----------------------------------------------------------------------------
module vhdl_token_scanner import vts_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_mode,
  input  logic [7:0]    in_source_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    out_token_kind,
  output logic [3:0]    out_error_code,
  output off_t          out_start_offset,
  output off_t          out_token_length,
  output line_t         out_start_line,
  output col_t          out_start_column,
  output line_t         out_end_line,
  output col_t          out_end_column,
  output logic          out_last_of_run
);

  step_t f_step, q_step;
  logic  f_valid, f_ready, q_valid, q_ready;
  tok_t  tok;

  vts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (in_mode),
    .source_byte(in_source_byte),
    .step_valid (f_valid),
    .step_ready (f_ready),
    .step       (f_step)
  );

  vts_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data (f_step),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_step)
  );

  vts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_valid(q_valid),
    .step_ready(q_ready),
    .step      (q_step),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (tok),
    .out_last  (out_last_of_run)
  );

  assign out_token_kind   = tok.kind;
  assign out_error_code   = tok.err;
  assign out_start_offset = tok.first.off;
  assign out_token_length = tok.stop.off - tok.first.off;
  assign out_start_line   = tok.first.line;
  assign out_start_column = tok.first.col;
  assign out_end_line     = tok.stop.line;
  assign out_end_column   = tok.stop.col;

endmodule

@@ src/vts_checker.sv @@
// ----------------------------------------------------------------------------
// VHDL token scanner checker
// Port-level properties of the token stream, bound to the top level.
// ----------------------------------------------------------------------------
module vts_checker import vts_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_token_kind,
  input logic [3:0] out_error_code,
  input off_t       out_token_length,
  input line_t      out_start_line,
  input col_t       out_start_column,
  input line_t      out_end_line,
  input col_t       out_end_column,
  input logic       out_last_of_run
);

  // A stalled beat holds its valid, kind, length and last flag.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
                                $stable(out_token_length) && $stable(out_last_of_run))
    else $error("output beat changed while stalled");

  // Only invalid tokens carry an error code.
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_token_kind == K_INVALID) == (out_error_code != E_NONE)))
    else $error("error code does not match token kind");

  // The end-of-file token closes its run.
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_EOF |-> out_last_of_run)
    else $error("end-of-file token not last of run");

  // The end-of-file token is empty.
  a_eof_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_EOF |->
      out_token_length == '0 && out_start_line == out_end_line &&
      out_start_column == out_end_column)
    else $error("end-of-file token is not empty");

endmodule

bind vhdl_token_scanner vts_checker u_vts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_kind  (out_token_kind),
  .out_error_code  (out_error_code),
  .out_token_length(out_token_length),
  .out_start_line  (out_start_line),
  .out_start_column(out_start_column),
  .out_end_line    (out_end_line),
  .out_end_column  (out_end_column),
  .out_last_of_run (out_last_of_run)
);

@@ sim/vts_token_checker.sv @@
// ----------------------------------------------------------------------------
// VHDL token scanner checker
// Watches both channels of the scanner. Every accepted input beat runs
// through a cycle-free model of the lexer, and the tokens it predicts are
// queued. Every accepted output beat is compared field by field with the
// oldest queued token.
// ----------------------------------------------------------------------------
module vts_token_checker import vts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_source_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_token_kind,
  input  logic [3:0] out_error_code,
  input  off_t       out_start_offset,
  input  off_t       out_token_length,
  input  line_t      out_start_line,
  input  col_t       out_start_column,
  input  line_t      out_end_line,
  input  col_t       out_end_column,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_COMMENT, ST_IDENT, ST_EXTID, ST_EXTID_ESC, ST_DEC, ST_BASED,
    ST_BASED_AFTER, ST_BEXP_SIGN, ST_BEXP_FIRST, ST_BEXP_DIG, ST_FRAC,
    ST_EXP_SIGN, ST_EXP_FIRST, ST_EXP_DIG, ST_STRING, ST_STR_ESC, ST_CHAR,
    ST_SYM2
  } lex_state_e;

  typedef struct {
    logic [3:0] kind;
    logic [3:0] err;
    off_t       start_off;
    off_t       length;
    line_t      start_line;
    col_t       start_col;
    line_t      end_line;
    col_t       end_col;
    logic       last;
  } token_rec_t;

  localparam int MAX_TOKENS = 8;

  token_rec_t expected_tokens[$];
  token_rec_t run_tokens[MAX_TOKENS];
  int         run_count;

  logic [7:0] window[3];
  int         window_fill;
  lex_state_e lex_state;
  pos_t       cursor;
  pos_t       tok_start;
  logic       bad_sep;
  logic       real_flag;
  int         char_left;
  logic [7:0] prev_byte;

  function automatic logic letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF;
  endfunction

  function automatic logic exp_mark(input logic [7:0] c);
    return c == CH_UE || c == CH_LE;
  endfunction

  function automatic logic delimiter(input logic [7:0] c);
    case (c)
      CH_AMP, CH_QUOTE, CH_LPAR, CH_RPAR, CH_STAR, CH_PLUS, CH_COMMA, CH_MINUS,
      CH_DOT, CH_SLASH, CH_COLON, CH_SEMI, CH_LT, CH_EQ, CH_GT, CH_BAR, CH_LBRK,
      CH_RBRK, CH_QMARK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic pair_symbol(input logic [7:0] a, input logic [7:0] b);
    if (b == CH_EQ) return a == CH_COLON || a == CH_LT || a == CH_GT || a == CH_SLASH;
    if (b == CH_GT) return a == CH_EQ || a == CH_LT;
    if (b == CH_STAR) return a == CH_STAR;
    return 1'b0;
  endfunction

  task automatic clear_lexer();
    window_fill = 0;
    lex_state   = ST_IDLE;
    cursor.off  = '0;
    cursor.line = line_t'(1);
    cursor.col  = col_t'(1);
    tok_start   = '0;
    bad_sep     = 1'b0;
    real_flag   = 1'b0;
    char_left   = 0;
    prev_byte   = 8'h00;
  endtask

  task automatic move_cursor(input logic [7:0] c);
    cursor.off = cursor.off + off_t'(1);
    if (c == CH_LF) begin
      if (cursor.line != {LINE_W{1'b1}}) cursor.line = cursor.line + line_t'(1);
      cursor.col = col_t'(1);
    end else if (cursor.col != {COL_W{1'b1}}) begin
      cursor.col = cursor.col + col_t'(1);
    end
    prev_byte = c;
  endtask

  task automatic push_token(input logic [3:0] kind, input logic [3:0] err);
    lex_state = ST_IDLE;
    bad_sep   = 1'b0;
    real_flag = 1'b0;
    if (run_count < MAX_TOKENS) begin
      run_tokens[run_count].kind       = kind;
      run_tokens[run_count].err        = err;
      run_tokens[run_count].start_off  = tok_start.off;
      run_tokens[run_count].length     = cursor.off - tok_start.off;
      run_tokens[run_count].start_line = tok_start.line;
      run_tokens[run_count].start_col  = tok_start.col;
      run_tokens[run_count].end_line   = cursor.line;
      run_tokens[run_count].end_col    = cursor.col;
      run_tokens[run_count].last       = 1'b0;
      run_count++;
    end
  endtask

  task automatic close_ident();
    if (bad_sep || prev_byte == CH_UNDER) push_token(K_INVALID, E_IDENT);
    else push_token(K_IDENT, E_NONE);
  endtask

  task automatic check_underscore(input logic [7:0] c, input logic [7:0] nxt,
                                  input logic based);
    if (c == CH_UNDER) begin
      if (based) begin
        if (!(letter(prev_byte) || numeral(prev_byte)) || !(letter(nxt) || numeral(nxt)))
          bad_sep = 1'b1;
      end else if (!numeral(prev_byte) || !numeral(nxt)) begin
        bad_sep = 1'b1;
      end
    end
  endtask

  // Consumes one byte; a byte that ends a token or a comment, or is no exponent
  // sign, is looked at again in the new state, hence the loop.
  task automatic scan_char(input logic [7:0] c, input logic [7:0] p1,
                           input logic [7:0] p2, input logic [7:0] p3);
    bit done;
    done = 0;
    while (!done) begin
      case (lex_state)
        ST_IDLE: begin
          done = 1;
          if (blank(c)) begin
            move_cursor(c);
          end else if (c == CH_MINUS && p1 == CH_MINUS) begin
            lex_state = ST_COMMENT;
            move_cursor(c);
          end else begin
            tok_start = cursor;
            bad_sep   = 1'b0;
            real_flag = 1'b0;
            if (letter(c)) begin
              lex_state = ST_IDENT;
              move_cursor(c);
            end else if (c == CH_BSLASH) begin
              lex_state = ST_EXTID;
              move_cursor(c);
            end else if (numeral(c)) begin
              lex_state = ST_DEC;
              move_cursor(c);
            end else if (c == CH_DQUOTE) begin
              lex_state = ST_STRING;
              move_cursor(c);
            end else if (c == CH_QUOTE && ((p1 == CH_QUOTE && p2 == CH_QUOTE && p3 == CH_QUOTE)
                         || (p1 != CH_NUL && p2 == CH_QUOTE && p1 != CH_LF))) begin
              char_left = (p1 == CH_QUOTE && p2 == CH_QUOTE && p3 == CH_QUOTE) ? 3 : 2;
              lex_state = ST_CHAR;
              move_cursor(c);
            end else if (delimiter(c)) begin
              move_cursor(c);
              if (pair_symbol(c, p1)) lex_state = ST_SYM2;
              else push_token(K_SYMBOL, E_NONE);
            end else begin
              move_cursor(c);
              push_token(K_INVALID, E_BAD_CHAR);
            end
          end
        end
        ST_COMMENT: begin
          if (c == CH_LF) begin
            lex_state = ST_IDLE;
          end else begin
            move_cursor(c);
            done = 1;
          end
        end
        ST_IDENT: begin
          if (letter(c) || numeral(c) || c == CH_UNDER) begin
            if (c == CH_UNDER && prev_byte == CH_UNDER) bad_sep = 1'b1;
            move_cursor(c);
            done = 1;
          end else begin
            close_ident();
          end
        end
        ST_EXTID: begin
          move_cursor(c);
          if (c == CH_BSLASH) begin
            if (p1 == CH_BSLASH) lex_state = ST_EXTID_ESC;
            else push_token(K_EXTID, E_NONE);
          end
          done = 1;
        end
        ST_EXTID_ESC: begin
          move_cursor(c);
          lex_state = ST_EXTID;
          done = 1;
        end
        ST_DEC: begin
          if (numeral(c) || c == CH_UNDER) begin
            check_underscore(c, p1, 1'b0);
            move_cursor(c);
            done = 1;
          end else if (bad_sep) begin
            push_token(K_INVALID, E_DEC_SEP);
          end else if (c == CH_HASH) begin
            bad_sep = 1'b0;
            real_flag = 1'b0;
            lex_state = ST_BASED;
            move_cursor(c);
            done = 1;
          end else if (c == CH_DOT && numeral(p1)) begin
            lex_state = ST_FRAC;
            move_cursor(c);
            done = 1;
          end else if (exp_mark(c)) begin
            lex_state = ST_EXP_SIGN;
            move_cursor(c);
            done = 1;
          end else begin
            push_token(K_INT, E_NONE);
          end
        end
        ST_BASED: begin
          done = 1;
          if (c != CH_HASH) begin
            if (c == CH_DOT) real_flag = 1'b1;
            check_underscore(c, p1, 1'b1);
            move_cursor(c);
          end else begin
            move_cursor(c);
            if (bad_sep) push_token(K_INVALID, E_BASED_SEP);
            else lex_state = ST_BASED_AFTER;
          end
        end
        ST_BASED_AFTER: begin
          if (exp_mark(c)) begin
            real_flag = 1'b1;
            lex_state = ST_BEXP_SIGN;
            move_cursor(c);
            done = 1;
          end else begin
            push_token(real_flag ? K_REAL : K_INT, E_NONE);
          end
        end
        ST_BEXP_SIGN, ST_EXP_SIGN: begin
          lex_state = (lex_state == ST_BEXP_SIGN) ? ST_BEXP_FIRST : ST_EXP_FIRST;
          if (c == CH_PLUS || c == CH_MINUS) begin
            move_cursor(c);
            done = 1;
          end
        end
        ST_BEXP_FIRST, ST_EXP_FIRST: begin
          if (numeral(c)) begin
            lex_state = (lex_state == ST_BEXP_FIRST) ? ST_BEXP_DIG : ST_EXP_DIG;
            move_cursor(c);
            done = 1;
          end else begin
            push_token(K_INVALID, (lex_state == ST_BEXP_FIRST) ? E_BEXP_EMPTY : E_EXP_EMPTY);
          end
        end
        ST_BEXP_DIG, ST_EXP_DIG: begin
          if (numeral(c) || c == CH_UNDER) begin
            check_underscore(c, p1, 1'b0);
            move_cursor(c);
            done = 1;
          end else if (bad_sep) begin
            push_token(K_INVALID, (lex_state == ST_BEXP_DIG) ? E_BEXP_SEP : E_EXP_SEP);
          end else begin
            push_token(K_REAL, E_NONE);
          end
        end
        ST_FRAC: begin
          if (numeral(c) || c == CH_UNDER) begin
            check_underscore(c, p1, 1'b0);
            move_cursor(c);
            done = 1;
          end else if (bad_sep) begin
            push_token(K_INVALID, E_FRAC_SEP);
          end else if (exp_mark(c)) begin
            lex_state = ST_EXP_SIGN;
            move_cursor(c);
            done = 1;
          end else begin
            push_token(K_REAL, E_NONE);
          end
        end
        ST_STRING: begin
          move_cursor(c);
          if (c == CH_DQUOTE) begin
            if (p1 == CH_DQUOTE) lex_state = ST_STR_ESC;
            else push_token(K_STRING, E_NONE);
          end
          done = 1;
        end
        ST_STR_ESC: begin
          move_cursor(c);
          lex_state = ST_STRING;
          done = 1;
        end
        ST_CHAR: begin
          move_cursor(c);
          if (char_left <= 1) push_token(K_CHAR, E_NONE);
          else char_left--;
          done = 1;
        end
        ST_SYM2: begin
          move_cursor(c);
          push_token(K_SYMBOL, E_NONE);
          done = 1;
        end
        default: lex_state = ST_IDLE;
      endcase
    end
  endtask

  // Whatever token is still open when the source ends.
  task automatic close_at_end();
    case (lex_state)
      ST_IDENT:                   close_ident();
      ST_EXTID, ST_EXTID_ESC:     push_token(K_INVALID, E_EXTID_OPEN);
      ST_DEC:                     push_token(bad_sep ? K_INVALID : K_INT,
                                             bad_sep ? E_DEC_SEP : E_NONE);
      ST_BASED:                   push_token(K_INVALID, E_BASED_OPEN);
      ST_BASED_AFTER:             push_token(real_flag ? K_REAL : K_INT, E_NONE);
      ST_BEXP_SIGN, ST_BEXP_FIRST: push_token(K_INVALID, E_BEXP_EMPTY);
      ST_BEXP_DIG:                push_token(bad_sep ? K_INVALID : K_REAL,
                                             bad_sep ? E_BEXP_SEP : E_NONE);
      ST_FRAC:                    push_token(bad_sep ? K_INVALID : K_REAL,
                                             bad_sep ? E_FRAC_SEP : E_NONE);
      ST_EXP_SIGN, ST_EXP_FIRST:  push_token(K_INVALID, E_EXP_EMPTY);
      ST_EXP_DIG:                 push_token(bad_sep ? K_INVALID : K_REAL,
                                             bad_sep ? E_EXP_SEP : E_NONE);
      ST_STRING, ST_STR_ESC:      push_token(K_INVALID, E_STRING_OPEN);
      ST_CHAR:                    push_token(K_CHAR, E_NONE);
      ST_SYM2:                    push_token(K_SYMBOL, E_NONE);
      default:                    lex_state = ST_IDLE;
    endcase
  endtask

  task automatic predict_beat(input logic mode, input logic [7:0] b);
    int n;
    logic [7:0] q1, q2;
    run_count = 0;
    if (mode == MODE_BYTE) begin
      if (window_fill < 3) begin
        window[window_fill] = b;
        window_fill++;
      end else begin
        scan_char(window[0], window[1], window[2], b);
        window[0] = window[1];
        window[1] = window[2];
        window[2] = b;
      end
    end else begin
      n = window_fill;
      for (int k = 0; k < n; k++) begin
        q1 = (k + 1 < n) ? window[k + 1] : CH_NUL;
        q2 = (k + 2 < n) ? window[k + 2] : CH_NUL;
        scan_char(window[k], q1, q2, CH_NUL);
      end
      close_at_end();
      tok_start = cursor;
      push_token(K_EOF, E_NONE);
      clear_lexer();
    end
    if (run_count > 0) run_tokens[run_count - 1].last = 1'b1;
    for (int k = 0; k < run_count; k++) expected_tokens = {expected_tokens, run_tokens[k]};
  endtask

  task automatic compare_beat();
    token_rec_t e;
    bit bad;
    if (expected_tokens.size() == 0) begin
      $error("token beat with nothing expected: kind %0d offset %0d",
             out_token_kind, out_start_offset);
      fail_count++;
      return;
    end
    e = expected_tokens.pop_front();
    bad = 0;
    if (out_token_kind !== e.kind) begin
      $error("token_kind: expected %0d, got %0d", e.kind, out_token_kind); bad = 1;
    end
    if (out_error_code !== e.err) begin
      $error("error_code: expected %0d, got %0d", e.err, out_error_code); bad = 1;
    end
    if (out_start_offset !== e.start_off) begin
      $error("start_offset: expected %0d, got %0d", e.start_off, out_start_offset); bad = 1;
    end
    if (out_token_length !== e.length) begin
      $error("token_length: expected %0d, got %0d", e.length, out_token_length); bad = 1;
    end
    if (out_start_line !== e.start_line) begin
      $error("start_line: expected %0d, got %0d", e.start_line, out_start_line); bad = 1;
    end
    if (out_start_column !== e.start_col) begin
      $error("start_column: expected %0d, got %0d", e.start_col, out_start_column); bad = 1;
    end
    if (out_end_line !== e.end_line) begin
      $error("end_line: expected %0d, got %0d", e.end_line, out_end_line); bad = 1;
    end
    if (out_end_column !== e.end_col) begin
      $error("end_column: expected %0d, got %0d", e.end_col, out_end_column); bad = 1;
    end
    if (out_last_of_run !== e.last) begin
      $error("last_of_run: expected %0d, got %0d", e.last, out_last_of_run); bad = 1;
    end
    if (bad) fail_count++;
  endtask

  // Input prediction runs first, though a token never leaves in the cycle
  // its byte arrives.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_lexer();
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) predict_beat(in_mode, in_source_byte);
      if (out_valid && out_ready) compare_beat();
    end
    pending = expected_tokens.size();
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// VHDL token scanner testbench
// Feeds the scanner directed and randomly built VHDL fragments, with end
// markers between sources, under three patterns of idling on both channels.
// A checker beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
module tb import vts_pkg::*; ();

  localparam int STALL_LIMIT = 5000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_mode;
  logic [7:0] in_source_byte;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] out_token_kind;
  logic [3:0] out_error_code;
  off_t       out_start_offset;
  off_t       out_token_length;
  line_t      out_start_line;
  col_t       out_start_column;
  line_t      out_end_line;
  col_t       out_end_column;
  logic       out_last_of_run;
  int         fail_count;
  int         pending;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         quiet_cycles;

  vhdl_token_scanner uut (.*);

  vts_token_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL vhdl_token_scanner");
      $finish;
    end
  end

  task automatic send_beat(input logic mode, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_source_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(MODE_BYTE, s[i]);
  endtask

  function automatic string pick(input string opts[]);
    return opts[$urandom_range(opts.size() - 1)];
  endfunction

  function automatic string some_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%c", 8'h30 + $urandom_range(9))};
    return s;
  endfunction

  function automatic string some_word(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++)
      case ($urandom_range(5))
        0: s = {s, "_"};
        1: s = {s, $sformatf("%c", 8'h30 + $urandom_range(9))};
        2: s = {s, $sformatf("%c", 8'h41 + $urandom_range(25))};
        default: s = {s, $sformatf("%c", 8'h61 + $urandom_range(25))};
      endcase
    return s;
  endfunction

  // Mostly well-formed lexemes with random content, some broken ones and
  // some raw noise bytes.
  function automatic string make_fragment();
    string s;
    case ($urandom_range(13))
      0: s = {"x", some_word($urandom_range(6))};
      1: s = {"\\", some_word($urandom_range(4)), pick('{"\\", "\\\\a\\", ""})};
      2: s = {some_digits($urandom_range(1, 3)), pick('{"", "_1", "__2", "_"})};
      3: s = {some_digits(1), ".", some_digits($urandom_range(1, 2)),
              pick('{"", "e", "E+", "e-3", "e1_2", "_", "e2__1", "E"})};
      4: s = {"16#", some_word($urandom_range(0, 3)), pick('{"#", ".a#", "#e+4", "#E", "", "#e-"})};
      5: s = {"\"", some_word($urandom_range(3)), pick('{"\"", "\"\"x\"", ""})};
      6: s = {"'", $sformatf("%c", $urandom_range(32, 126)), "'"};
      7: s = pick('{":=", "<=", ">=", "/=", "=>", "**", "<>", "&", "(", ")", ";",
                    "|", "[", "]", "?", ",", ".", "+", "'''", "'", "-"});
      8: s = pick('{" ", "\t", "\n", "\r", "\f", "  "});
      9: s = {"-- ", some_word($urandom_range(4)), "\n"};
      10: s = $sformatf("%c", $urandom_range(255));
      11: s = {$sformatf("%c", $urandom_range(255)), $sformatf("%c", $urandom_range(255))};
      12: s = {some_digits(1), pick('{"e", "E5", "#", "#1_#", "#f__f#"})};
      default: s = pick('{" ", "\n"});
    endcase
    return s;
  endfunction

  task automatic random_phase(input int sent_goal);
    string s;
    int sent;
    sent = 0;
    while (sent < sent_goal) begin
      s = make_fragment();
      send_text(s);
      sent += s.len();
      if ($urandom_range(29) == 0) send_beat(MODE_END, 8'($urandom_range(255)));
    end
    send_beat(MODE_END, 8'($urandom_range(255)));
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_BYTE;
    in_source_byte = 8'h00;
    send_idle_pct  = 27;
    recv_idle_pct  = 72;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed sources: every token class but the integer, escapes, the triple
    // quote, comments, a zero byte, an invalid byte and an end right after the end.
    send_text("a\\b\\\\c\\ 1_0.5e-3 2#1.1#e4 \"s\"\"t\" ''' 'x' <=--c\n$");
    send_beat(MODE_BYTE, 8'h00);
    send_beat(MODE_BYTE, 8'hFF);
    send_beat(MODE_END, 8'hFF);
    send_beat(MODE_END, 8'h00);
    send_text("9e");
    send_beat(MODE_END, 8'h00);
    send_text("'a");
    send_beat(MODE_END, 8'h00);

    random_phase(70);
    send_idle_pct = 72;
    recv_idle_pct = 27;
    random_phase(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(70);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS vhdl_token_scanner");
    end else begin
      $display("FAIL vhdl_token_scanner");
    end
    $finish;
  end

endmodule
